// File: hw/rtl/char_lcd_nibble_write_sequencer_defines.svh
// Assertion macros shared by the character LCD sequencer modules.
`ifndef CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITE_SEQUENCER_DEFINES_SVH
`ifndef SYNTHESIS
`define CLCD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("clcd assertion failed");
`define CLCD_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("clcd reset assertion failed");
`else
`define CLCD_ASSERT(lbl, prop)
`define CLCD_ASSERT_RST(lbl, prop)
`endif
`endif

// File: hw/rtl/clcd_pkg.sv
// Types, codes and constants of the character LCD sequencer.
package clcd_pkg;

   localparam int OP_W      = 2;
   localparam int BYTE_W    = 8;
   localparam int NIB_W     = 4;
   localparam int HOLD_W    = 21;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 20;

   localparam logic [OP_W-1:0] OP_CMD  = 2'd0;
   localparam logic [OP_W-1:0] OP_CHAR = 2'd1;
   localparam logic [OP_W-1:0] OP_INIT = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_PULSE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE       = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_EXTRA   = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POWERUP      = 8'd3;

   localparam logic [15:0] RST_ENABLE_PULSE = 16'd1000;
   localparam logic [15:0] RST_SETTLE       = 16'd43;
   localparam logic [15:0] RST_LONG_EXTRA   = 16'd1487;
   localparam logic [19:0] RST_POWERUP      = 20'd300000;

   localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'h01;
   localparam logic [BYTE_W-1:0] CMD_HOME     = 8'h02;
   localparam logic [BYTE_W-1:0] CMD_FUNC_SET = 8'h2B;
   localparam logic [BYTE_W-1:0] CMD_DISP_ON  = 8'h0C;
   localparam logic [NIB_W-1:0]  INIT_NIBBLE  = 4'h2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [15:0] enable_pulse_us;
      logic [15:0] settle_us;
      logic [15:0] long_extra_us;
      logic [19:0] powerup_us;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [BYTE_W-1:0] data_byte;
   } entry_type;

   typedef struct packed {
      logic              rs_pin;
      logic              en_pin;
      logic [NIB_W-1:0]  data_nibble;
      logic [HOLD_W-1:0] hold_us;
      logic              last_item;
   } pin_state_type;

   function automatic logic [BYTE_W-1:0] init_byte(input logic [1:0] idx);
      logic [BYTE_W-1:0] b;
      unique case (idx)
         2'd0:    b = CMD_FUNC_SET;
         2'd1:    b = CMD_CLEAR;
         default: b = CMD_DISP_ON;
      endcase
      return b;
   endfunction

endpackage

// File: hw/rtl/clcd_front.sv
// Request intake: drop unused opcodes and queue the rest for the sequencer.
`include "char_lcd_nibble_write_sequencer_defines.svh"
module clcd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic [1:0]          req_tuser,
   output logic                q_valid,
   output clcd_pkg::entry_type q_entry,
   input  logic                q_pop
);
   import clcd_pkg::*;

   entry_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   entry_type          new_entry;

   assign req_tready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && (req_tuser != OP_NONE);
   assign new_entry  = '{opcode: req_tuser, data_byte: req_tdata};
   assign q_valid    = (count_ff != '0);
   assign q_entry    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_entry;
      end
   end

   `CLCD_ASSERT(a_count_bound, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `CLCD_ASSERT(a_pop_nonempty, q_pop |-> (count_ff != '0))
   `CLCD_ASSERT_RST(a_reset_empty, reset |=> (count_ff == '0))

endmodule

// File: hw/rtl/clcd_back.sv
// Pin state sequencer: expand queued bytes and init requests into timed states.
`include "char_lcd_nibble_write_sequencer_defines.svh"
module clcd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  clcd_pkg::cfg_type       cfg,
   input  logic                    q_valid,
   input  clcd_pkg::entry_type     q_entry,
   output logic                    q_pop,
   output logic                    out_valid,
   input  logic                    out_ready,
   output clcd_pkg::pin_state_type out_state
);
   import clcd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PRE  = 2'd1;
   localparam logic [1:0] ST_BYTE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [2:0]        sub_ff, sub_in;
   logic [1:0]        idx_ff, idx_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              rs_level_ff;
   logic [NIB_W-1:0]  nib_level_ff;
   logic              valid_ff;
   pin_state_type     out_ff, pin;

   logic              adv, emit, last, take, is_char, is_long;
   logic [BYTE_W-1:0] cur_byte;
   logic [16:0]       settle_sum;
   logic [HOLD_W-1:0] pulse_hold, settle_hold;

   assign adv        = !valid_ff || out_ready;
   assign emit       = adv && (state_ff != ST_IDLE);
   assign is_char    = (op_ff == OP_CHAR);
   assign cur_byte   = (op_ff == OP_INIT) ? init_byte(idx_ff) : byte_ff;
   assign is_long    = !is_char && ((cur_byte == CMD_CLEAR) || (cur_byte == CMD_HOME));
   assign settle_sum = {1'b0, cfg.settle_us}
                     + (is_long ? {1'b0, cfg.long_extra_us} : 17'd0);
   assign settle_hold = HOLD_W'(settle_sum);
   assign pulse_hold  = HOLD_W'(cfg.enable_pulse_us);
   assign last        = (state_ff == ST_BYTE) && (sub_ff == 3'd4)
                      && ((op_ff != OP_INIT) || (idx_ff == 2'd2));
   assign take        = q_valid && ((state_ff == ST_IDLE) || (emit && last));
   assign q_pop       = take;

   always_comb begin
      pin = '0;
      unique case (state_ff)
         ST_PRE: begin
            unique case (sub_ff)
               3'd0: pin = '{rs_level_ff, 1'b0, nib_level_ff,
                             HOLD_W'(cfg.powerup_us), 1'b0};
               3'd1: pin = '{1'b0, 1'b0, INIT_NIBBLE, '0, 1'b0};
               3'd2: pin = '{1'b0, 1'b1, INIT_NIBBLE, pulse_hold, 1'b0};
               default: pin = '0;
            endcase
         end
         ST_BYTE: begin
            unique case (sub_ff)
               3'd0: pin = '{is_char, 1'b0, cur_byte[7:4], '0, 1'b0};
               3'd1: pin = '{is_char, 1'b1, cur_byte[7:4], pulse_hold, 1'b0};
               3'd2: pin = '{is_char, 1'b0, cur_byte[3:0], '0, 1'b0};
               3'd3: pin = '{is_char, 1'b1, cur_byte[3:0], pulse_hold, 1'b0};
               3'd4: pin = '{is_char, 1'b0, cur_byte[3:0], settle_hold, last};
               default: pin = '0;
            endcase
         end
         default: pin = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      sub_in   = sub_ff;
      idx_in   = idx_ff;
      op_in    = op_ff;
      byte_in  = byte_ff;
      priority if (take) begin
         op_in    = q_entry.opcode;
         byte_in  = q_entry.data_byte;
         state_in = (q_entry.opcode == OP_INIT) ? ST_PRE : ST_BYTE;
         sub_in   = '0;
         idx_in   = '0;
      end else if (emit && last) begin
         state_in = ST_IDLE;
      end else if (emit) begin
         if (sub_ff == 3'd4 || (state_ff == ST_PRE && sub_ff == 3'd2)) begin
            if (state_ff == ST_BYTE) begin
               idx_in = idx_ff + 2'd1;
            end
            state_in = ST_BYTE;
            sub_in   = '0;
         end else begin
            sub_in = sub_ff + 3'd1;
         end
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sub_ff       <= '0;
         idx_ff       <= '0;
         valid_ff     <= 1'b0;
         rs_level_ff  <= 1'b0;
         nib_level_ff <= '0;
      end else begin
         state_ff <= state_in;
         sub_ff   <= sub_in;
         idx_ff   <= idx_in;
         if (emit) begin
            valid_ff     <= 1'b1;
            rs_level_ff  <= pin.rs_pin;
            nib_level_ff <= pin.data_nibble;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      byte_ff <= byte_in;
      if (emit) begin
         out_ff <= pin;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = out_ff;

   `CLCD_ASSERT(a_sub_bound, sub_ff <= 3'd4)
   `CLCD_ASSERT(a_idx_bound, idx_ff <= 2'd2)
   `CLCD_ASSERT(a_pre_init, (state_ff == ST_PRE) |-> (op_ff == OP_INIT))
   `CLCD_ASSERT(a_pop_when_free, q_pop |-> ((state_ff == ST_IDLE) || (emit && last)))

endmodule

// File: hw/rtl/char_lcd_nibble_write_sequencer.sv
// Character LCD 4-bit write sequencer: top level with configuration registers.
//
// Requests arrive on req_*: req_tuser holds the opcode (0 command byte,
// 1 character byte, 2 init, 3 dropped without result), req_tdata the byte.
// Each pin state leaves on rsp_*: RS, EN, D7..D4 and a hold time in
// microseconds; rsp_tlast marks the final state of a request.
// A byte gives 5 states, init gives 18 (power-up wait, nibble 2 strobe,
// then function set, clear and display on).
// One state is produced per cycle while rsp_tready is high; the first state of a
// request passes the queue, the sequencer state register and the output register,
// and the next request starts with no gap, set by the single state sequencer.
// A two-entry request queue sits in front of the sequencer; req_tready
// drops when it is full.
// When rsp_tready is low the output register holds its state, the
// sequencer waits and the queue fills.
// csr_* writes a register by index (0 enable pulse, 1 settle, 2 clear/home
// extra, 3 power-up); csr_ready is always high. Write only while idle.
// Reset restores the register defaults, empties the queue and zeroes the
// remembered RS and data line levels.
module char_lcd_nibble_write_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [0] rs_pin, [1] en_pin, [5:2] data_nibble,
                                    // [26:6] hold_us, [31:27] zero
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [19:0] csr_data
);
   import clcd_pkg::*;

   cfg_type       cfg_ff;
   logic          q_valid, q_pop;
   entry_type     q_entry;
   pin_state_type out_state;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable_pulse_us <= RST_ENABLE_PULSE;
         cfg_ff.settle_us       <= RST_SETTLE;
         cfg_ff.long_extra_us   <= RST_LONG_EXTRA;
         cfg_ff.powerup_us      <= RST_POWERUP;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ENABLE_PULSE: cfg_ff.enable_pulse_us <= csr_data[15:0];
            CSR_SETTLE:       cfg_ff.settle_us       <= csr_data[15:0];
            CSR_LONG_EXTRA:   cfg_ff.long_extra_us   <= csr_data[15:0];
            CSR_POWERUP:      cfg_ff.powerup_us      <= csr_data;
            default: ;
         endcase
      end
   end

   clcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .q_pop      (q_pop)
   );

   clcd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_state (out_state)
   );

   assign rsp_tdata = {5'b0, out_state.hold_us, out_state.data_nibble,
                       out_state.en_pin, out_state.rs_pin};
   assign rsp_tlast = out_state.last_item;

endmodule
